>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the event queue.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DOEQ_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("doeq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DOEQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("doeq assertion failed");

`endif

>>> hw/rtl/doeq_pkg.sv
// Shared types, constants and helper functions of the deadline ordered event queue.
// Depends on nothing; doeq_ctrl, the top level, both checkers and the testbench import it.
package doeq_pkg;

	// Store size and the derived index widths.
	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_RELEASE = 16;
	localparam int ADDR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int REL_W = $clog2(MAX_RELEASE + 1);

	// Request action codes.
	localparam logic [1:0] ACT_POST = 2'd0;
	localparam logic [1:0] ACT_CANCEL = 2'd1;
	localparam logic [1:0] ACT_TICK = 2'd2;

	// Result kind codes.
	localparam logic [1:0] KIND_POST = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_SCAN,
		ST_INS_TAIL,
		ST_CAN_SCAN,
		ST_RESP,
		ST_REL_RD,
		ST_REL_CHK,
		ST_REL_FLUSH
	} state_t;

	// One stored entry.
	typedef struct packed {
		logic [31:0] deadline;
		logic [31:0] id;
	} entry_t;

	// One result handed from the sequencer to the output register.
	typedef struct packed {
		logic        vld;
		logic [1:0]  kind;
		logic [31:0] id;
		logic        found;
		logic        full_err;
		logic        last;
	} result_t;

	// True when deadline a is earlier than or equal to deadline b, wrap-aware.
	function automatic logic not_after(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] diff;
		diff = b - a;
		return !diff[31];
	endfunction

	// Physical slot of the entry at position offs counted from the front.
	function automatic logic [ADDR_W-1:0] slot_addr(input logic [ADDR_W-1:0] base,
			input logic [CNT_W-1:0] offs);
		logic [CNT_W:0] sum;
		sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, base} + {1'b0, offs};
		if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
			sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

>>> hw/rtl/doeq_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on nothing.
module doeq_ram #(
	parameter int DEPTH = 16,
	parameter int DATA_W = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hw/rtl/doeq_ctrl.sv
// Sequencer of the event queue: scans, shifts and releases entries held in a circular RAM.
// Depends on doeq_pkg and doeq_ram.
module doeq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [30:0]        delay,
	input  logic [31:0]        cancel_id,
	input  logic               res_ready,
	output doeq_pkg::result_t  res
);
	import doeq_pkg::*;

	state_t state_q, state_d;

	logic [31:0] time_q, next_id_q;
	logic [31:0] new_dl_q, new_id_q, cid_q;
	logic [CNT_W-1:0] count_q, rd_idx_q;
	logic [ADDR_W-1:0] head_q, head_inc;
	logic rd_on_q, placed_q, hit_q;
	logic lookup_vld_s1;
	logic [CNT_W-1:0] lookup_idx_s1;
	entry_t carry_q;
	logic pend_vld_q;
	logic [31:0] pend_id_q;
	logic [REL_W-1:0] rel_n_q;
	result_t resp_q;

	logic rd_en, wr_en;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	entry_t rd_data, wr_data;

	logic accept, last_idx, ins_here, can_hit, due, rel_stop, scan_st, can_done;

	doeq_ram #(
		.DEPTH (QUEUE_DEPTH),
		.DATA_W($bits(entry_t))
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Decoded conditions used by both the next-state and the output logic.
	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign last_idx = (lookup_idx_s1 == count_q - CNT_W'(1));
	assign ins_here = !not_after(rd_data.deadline, new_dl_q);
	assign can_hit = (rd_data.id == cid_q);
	assign due = not_after(rd_data.deadline, time_q);
	assign rel_stop = (count_q == '0) || (rel_n_q == REL_W'(MAX_RELEASE));
	assign scan_st = (state_q == ST_INS_SCAN) || (state_q == ST_CAN_SCAN);
	assign can_done = (state_q == ST_CAN_SCAN) && lookup_vld_s1 && last_idx;
	assign head_inc = (head_q == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + ADDR_W'(1);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (action)
						ACT_POST: begin
							if (count_q == CNT_W'(QUEUE_DEPTH)) begin
								state_d = ST_RESP;
							end else if (count_q == '0) begin
								state_d = ST_INS_TAIL;
							end else begin
								state_d = ST_INS_SCAN;
							end
						end
						ACT_CANCEL: begin
							state_d = (count_q == '0) ? ST_RESP : ST_CAN_SCAN;
						end
						ACT_TICK: begin
							state_d = ST_REL_RD;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_INS_SCAN: begin
				if (lookup_vld_s1 && last_idx) begin
					state_d = ST_INS_TAIL;
				end
			end
			ST_INS_TAIL: begin
				state_d = ST_RESP;
			end
			ST_CAN_SCAN: begin
				if (lookup_vld_s1 && last_idx) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			ST_REL_RD: begin
				if (rel_stop) begin
					state_d = pend_vld_q ? ST_REL_FLUSH : ST_IDLE;
				end else begin
					state_d = ST_REL_CHK;
				end
			end
			ST_REL_CHK: begin
				if (due) begin
					if (!pend_vld_q || res_ready) begin
						state_d = ST_REL_RD;
					end
				end else begin
					state_d = pend_vld_q ? ST_REL_FLUSH : ST_IDLE;
				end
			end
			ST_REL_FLUSH: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Memory ports and the result offered to the output register.
	// Reads run one entry ahead of writes, so a write never hits a slot still to be read.
	always_comb begin
		rd_en = 1'b0;
		rd_addr = slot_addr(head_q, rd_idx_q);
		wr_en = 1'b0;
		wr_addr = slot_addr(head_q, lookup_idx_s1);
		wr_data = carry_q;
		res = '0;
		case (state_q)
			ST_INS_SCAN: begin
				rd_en = rd_on_q;
				if (lookup_vld_s1) begin
					if (placed_q) begin
						wr_en = 1'b1;
					end else if (ins_here) begin
						wr_en = 1'b1;
						wr_data = '{deadline: new_dl_q, id: new_id_q};
					end
				end
			end
			ST_INS_TAIL: begin
				wr_en = 1'b1;
				wr_addr = slot_addr(head_q, count_q);
				if (!placed_q) begin
					wr_data = '{deadline: new_dl_q, id: new_id_q};
				end
			end
			ST_CAN_SCAN: begin
				rd_en = rd_on_q;
				wr_addr = slot_addr(head_q, lookup_idx_s1 - CNT_W'(1));
				wr_data = rd_data;
				wr_en = lookup_vld_s1 && hit_q;
			end
			ST_RESP: begin
				res = resp_q;
				res.vld = 1'b1;
			end
			ST_REL_RD: begin
				rd_en = !rel_stop;
				rd_addr = head_q;
			end
			ST_REL_CHK: begin
				res.vld = due && pend_vld_q;
				res.kind = KIND_RELEASE;
				res.id = pend_id_q;
				res.last = 1'b0;
			end
			ST_REL_FLUSH: begin
				res.vld = 1'b1;
				res.kind = KIND_RELEASE;
				res.id = pend_id_q;
				res.last = 1'b1;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			time_q <= '0;
			next_id_q <= '0;
			count_q <= '0;
			head_q <= '0;
			rd_idx_q <= '0;
			rd_on_q <= 1'b0;
			lookup_vld_s1 <= 1'b0;
			placed_q <= 1'b0;
			hit_q <= 1'b0;
			pend_vld_q <= 1'b0;
			rel_n_q <= '0;
		end else begin
			state_q <= state_d;
			lookup_vld_s1 <= rd_on_q && scan_st;

			// Request intake.
			if (accept) begin
				case (action)
					ACT_POST: begin
						if (count_q != CNT_W'(QUEUE_DEPTH)) begin
							next_id_q <= next_id_q + 32'd1;
						end
						placed_q <= 1'b0;
						rd_idx_q <= '0;
						rd_on_q <= (count_q != '0) && (count_q != CNT_W'(QUEUE_DEPTH));
					end
					ACT_CANCEL: begin
						hit_q <= 1'b0;
						rd_idx_q <= '0;
						rd_on_q <= (count_q != '0);
					end
					ACT_TICK: begin
						time_q <= time_q + 32'd1;
						pend_vld_q <= 1'b0;
						rel_n_q <= '0;
					end
					default: begin
						rd_on_q <= 1'b0;
					end
				endcase
			end

			// Read index walks front to back during a scan.
			if (scan_st && rd_on_q) begin
				if (rd_idx_q == count_q - CNT_W'(1)) begin
					rd_on_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end
			end

			// Insertion point found: later entries ripple one slot back.
			if (state_q == ST_INS_SCAN && lookup_vld_s1 && !placed_q && ins_here) begin
				placed_q <= 1'b1;
			end
			if (state_q == ST_INS_TAIL) begin
				count_q <= count_q + CNT_W'(1);
			end

			// First matching id of a cancel; later entries ripple one slot forward.
			if (state_q == ST_CAN_SCAN && lookup_vld_s1 && can_hit) begin
				hit_q <= 1'b1;
			end
			if (can_done && (hit_q || can_hit)) begin
				count_q <= count_q - CNT_W'(1);
			end

			// A due front entry is popped and held until the next one is judged.
			if (state_q == ST_REL_CHK && due && (!pend_vld_q || res_ready)) begin
				pend_vld_q <= 1'b1;
				head_q <= head_inc;
				count_q <= count_q - CNT_W'(1);
				rel_n_q <= rel_n_q + REL_W'(1);
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		lookup_idx_s1 <= rd_idx_q;
		if (accept) begin
			case (action)
				ACT_POST: begin
					new_dl_q <= time_q + {1'b0, delay};
					new_id_q <= next_id_q;
					if (count_q == CNT_W'(QUEUE_DEPTH)) begin
						resp_q <= '{vld: 1'b1, kind: KIND_POST, id: 32'd0, found: 1'b0,
							full_err: 1'b1, last: 1'b1};
					end else begin
						resp_q <= '{vld: 1'b1, kind: KIND_POST, id: next_id_q, found: 1'b0,
							full_err: 1'b0, last: 1'b1};
					end
				end
				ACT_CANCEL: begin
					cid_q <= cancel_id;
					resp_q <= '{vld: 1'b1, kind: KIND_CANCEL, id: cancel_id, found: 1'b0,
						full_err: 1'b0, last: 1'b1};
				end
				default: begin
					resp_q <= resp_q;
				end
			endcase
		end
		if (state_q == ST_INS_SCAN && lookup_vld_s1 && (placed_q || ins_here)) begin
			carry_q <= rd_data;
		end
		if (can_done) begin
			resp_q.found <= hit_q || can_hit;
		end
		if (state_q == ST_REL_CHK && due && (!pend_vld_q || res_ready)) begin
			pend_id_q <= rd_data.id;
		end
	end

endmodule

>>> hw/rtl/deadline_ordered_event_queue.sv
// Deadline ordered event queue, top level: sequencer plus output register.
// Post: scan, tail write, result; an empty store skips the scan, a full one both.
// Cancel: scan, then result; on an empty store, result only. One request at a time.
// Tick: front entries are read, then judged, in the RAM loop; output stalls can hold it.
// Reset (asynchronous, active low) empties the queue and clears time and id counters;
// entry RAM contents are not cleared. Depends on doeq_pkg and doeq_ctrl.
module deadline_ordered_event_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [30:0] delay,
	input  logic [31:0] cancel_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [31:0] event_id,
	output logic        found,
	output logic        full_error,
	output logic        last
);
	import doeq_pkg::*;

	result_t res;
	logic res_ready;
	logic out_valid_q;
	logic [1:0] kind_q;
	logic [31:0] event_id_q;
	logic found_q, full_error_q, last_q;

	doeq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.delay    (delay),
		.cancel_id(cancel_id),
		.res_ready(res_ready),
		.res      (res)
	);

	// The output register takes a new result when empty or being drained.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.vld) begin
			kind_q <= res.kind;
			event_id_q <= res.id;
			found_q <= res.found;
			full_error_q <= res.full_err;
			last_q <= res.last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign event_id = event_id_q;
	assign found = found_q;
	assign full_error = full_error_q;
	assign last = last_q;

endmodule

>>> hw/rtl/doeq_checker.sv
// Port-level checker of the event queue and the bind that attaches it to the top level.
// Depends on doeq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module doeq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  kind,
	input logic [31:0] event_id,
	input logic        found,
	input logic        full_error,
	input logic        last
);
	import doeq_pkg::*;

	// A stalled result stays valid and keeps its kind, id and last flag.
	`DOEQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(event_id) && $stable(kind) && $stable(last))

	// Every post and cancel result carries last.
	`DOEQ_ASSERT_IMPL(a_single_last, clk, arst_n, out_valid && kind != KIND_RELEASE, last)

	// Only a cancel answer reports a found entry.
	`DOEQ_ASSERT_IMPL(a_found_cancel, clk, arst_n, out_valid && found, kind == KIND_CANCEL && !full_error)

	// A refused post carries id zero.
	`DOEQ_ASSERT_IMPL(a_full_post, clk, arst_n, out_valid && full_error, kind == KIND_POST && event_id == 32'd0 && last)

endmodule

bind deadline_ordered_event_queue doeq_checker u_doeq_checker (.*);

>>> sim/doeq_result_checker.sv
// Result checker for the deadline ordered event queue testbench.
// Watches the request and result channels, predicts every result and compares them.
// Depends on doeq_pkg for the codes, the store size and the entry layout.
module doeq_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  action,
	input  logic [30:0] delay,
	input  logic [31:0] cancel_id,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] event_id,
	input  logic        found,
	input  logic        full_error,
	input  logic        last,
	output int          fail_count,
	output int          pending,
	output int          checked_count,
	output int          release_count,
	output int          refuse_count,
	output int          hit_count
);
	import doeq_pkg::*;

	// One awaited result, field by field.
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] id;
		logic        found;
		logic        full_err;
		logic        last;
	} answer_t;

	// Predicted queue contents, front first, and the predicted counters.
	entry_t      schedule[$];
	answer_t     awaited_answers[$];
	logic [31:0] now_tick;
	logic [31:0] id_next;

	// Deadline a is due no later than b, with wraparound.
	function automatic bit due_by(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] gap;
		gap = b - a;
		return !gap[31];
	endfunction

	// Apply one accepted request to the predicted queue and queue its results.
	task automatic predict_answers(input logic [1:0] act, input logic [30:0] dly,
			input logic [31:0] cid);
		logic [31:0] due;
		int          pos;
		bit          hit;
		bit          held_valid;
		answer_t     held;
		int          n;
		case (act)
			ACT_POST: begin
				if (schedule.size() >= QUEUE_DEPTH) begin
					awaited_answers.push_back('{KIND_POST, 32'd0, 1'b0, 1'b1, 1'b1});
				end else begin
					// Insert after every entry due no later, so ties keep post order.
					due = now_tick + {1'b0, dly};
					pos = 0;
					while (pos < schedule.size() && due_by(schedule[pos].deadline, due))
						pos++;
					schedule.insert(pos, '{deadline: due, id: id_next});
					awaited_answers.push_back('{KIND_POST, id_next, 1'b0, 1'b0, 1'b1});
					id_next = id_next + 32'd1;
				end
			end
			ACT_CANCEL: begin
				hit = 1'b0;
				for (int i = 0; i < schedule.size(); i++) begin
					if (!hit && schedule[i].id == cid) begin
						schedule.delete(i);
						hit = 1'b1;
					end
				end
				awaited_answers.push_back('{KIND_CANCEL, cid, hit, 1'b0, 1'b1});
			end
			ACT_TICK: begin
				// Release up to MAX_RELEASE due entries from the front; the final one carries last.
				now_tick = now_tick + 32'd1;
				n = 0;
				held_valid = 1'b0;
				while (n < MAX_RELEASE && schedule.size() > 0 &&
						due_by(schedule[0].deadline, now_tick)) begin
					if (held_valid)
						awaited_answers.push_back(held);
					held = '{KIND_RELEASE, schedule[0].id, 1'b0, 1'b0, 1'b0};
					held_valid = 1'b1;
					schedule.delete(0);
					n++;
				end
				if (held_valid) begin
					held.last = 1'b1;
					awaited_answers.push_back(held);
				end
			end
			default: begin
			end
		endcase
	endtask

	// Compare one accepted result with the oldest awaited one.
	task automatic check_answer();
		answer_t want;
		if (awaited_answers.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("Unexpected result: kind %0d id %08h found %0b full %0b last %0b",
					kind, event_id, found, full_error, last);
		end else begin
			want = awaited_answers[0];
			awaited_answers.delete(0);
			checked_count++;
			if (want.kind == KIND_RELEASE)
				release_count++;
			if (want.full_err)
				refuse_count++;
			if (want.found)
				hit_count++;
			if (kind !== want.kind || event_id !== want.id || found !== want.found ||
					full_error !== want.full_err || last !== want.last) begin
				fail_count++;
				if (fail_count <= 10)
					$display("Mismatch: expected kind %0d id %08h found %0b full %0b last %0b,%s",
						want.kind, want.id, want.found, want.full_err, want.last,
						$sformatf(" got kind %0d id %08h found %0b full %0b last %0b",
							kind, event_id, found, full_error, last));
			end
		end
	endtask

	// Results are checked before the request of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			schedule.delete();
			awaited_answers.delete();
			now_tick = 32'd0;
			id_next = 32'd0;
			fail_count = 0;
			checked_count = 0;
			release_count = 0;
			refuse_count = 0;
			hit_count = 0;
		end else begin
			if (out_valid && !out_stall)
				check_answer();
			if (in_valid && !in_stall)
				predict_answers(action, delay, cancel_id);
		end
		pending = awaited_answers.size();
	end

endmodule

>>> sim/tb_deadline_ordered_event_queue.sv
// Testbench top for the deadline ordered event queue: clock, reset, requests,
// result-side stalls and the verdict. Depends on doeq_pkg, the block and doeq_result_checker.
module tb_deadline_ordered_event_queue;
	import doeq_pkg::*;

	// The action code that the block ignores.
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_REQUESTS = 500;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES = 400;

	// Result-side stall patterns.
	typedef enum logic [1:0] {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_PATTERN
	} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [30:0] delay;
	logic [31:0] cancel_id;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  kind;
	logic [31:0] event_id;
	logic        found;
	logic        full_error;
	logic        last;

	int fail_count;
	int pending;
	int checked_count;
	int release_count;
	int refuse_count;
	int hit_count;

	int cycle_count = 0;
	int post_count = 0;
	int cancel_count = 0;
	int tick_count = 0;
	int ignored_count = 0;

	deadline_ordered_event_queue u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.delay      (delay),
		.cancel_id  (cancel_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.event_id   (event_id),
		.found      (found),
		.full_error (full_error),
		.last       (last)
	);

	doeq_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.delay         (delay),
		.cancel_id     (cancel_id),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.event_id      (event_id),
		.found         (found),
		.full_error    (full_error),
		.last          (last),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked_count (checked_count),
		.release_count (release_count),
		.refuse_count  (refuse_count),
		.hit_count     (hit_count)
	);

	// Clock with a period of four time units.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offer one request and hold it until the block takes it.
	task automatic issue(input logic [1:0] act, input logic [30:0] dly, input logic [31:0] cid);
		in_valid <= 1'b1;
		action <= act;
		delay <= dly;
		cancel_id <= cid;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		case (act)
			ACT_POST: post_count++;
			ACT_CANCEL: cancel_count++;
			ACT_TICK: tick_count++;
			default: ignored_count++;
		endcase
	endtask

	// Drop valid for a number of cycles between bursts.
	task automatic idle(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Stop sending until every predicted result has arrived.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Mostly short delays so entries come due, now and then the far extremes.
	function automatic logic [30:0] pick_delay();
		int r;
		r = $urandom_range(0, 39);
		if (r < 30)
			return 31'($urandom_range(0, 24));
		else if (r < 37)
			return 31'($urandom_range(0, 3));
		else if (r < 38)
			return 31'($urandom());
		else
			return 31'h7FFF_FFFF - 31'($urandom_range(0, 5));
	endfunction

	// Cancel ids: mostly ids that were handed out, some recent, some anything.
	function automatic logic [31:0] pick_cancel_id();
		int r;
		int lo;
		r = $urandom_range(0, 19);
		lo = (post_count > 20) ? post_count - 20 : 0;
		if (r < 10)
			return 32'($urandom_range(0, post_count + 1));
		else if (r < 17)
			return 32'($urandom_range(lo, post_count + 1));
		else
			return $urandom();
	endfunction

	// Result side: random stall segments, with a long hold every few segments.
	initial begin
		int       seg_len;
		int       seg;
		rx_mode_t mode;
		out_stall <= 1'b1;
		seg = 0;
		@(posedge arst_n);
		forever begin
			if (seg % 8 == 3) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				seg_len = $urandom_range(50, 300);
				mode = rx_mode_t'($urandom_range(0, 3));
				for (int i = 0; i < seg_len; i++) begin
					case (mode)
						RX_FREE: out_stall <= 1'b0;
						RX_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
						RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
						default: out_stall <= (i % 5 < 2);
					endcase
					@(posedge clk);
				end
			end
			seg++;
		end
	end

	// Request side: reset, a directed opening, random bursts, drain and verdict.
	initial begin
		int          burst_len;
		int          random_sent;
		int          r;
		bit          mid_drained;
		logic [1:0]  act;
		logic [30:0] dly;
		logic [31:0] cid;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= ACT_POST;
		delay <= 31'd0;
		cancel_id <= 32'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extreme delays, a tie, cancels that hit and miss, a two-entry release.
		issue(ACT_POST, 31'd0, 32'd0);
		issue(ACT_POST, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		issue(ACT_POST, 31'd0, 32'd0);
		issue(ACT_CANCEL, 31'd0, 32'd1);
		issue(ACT_CANCEL, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		issue(ACT_TICK, 31'd0, 32'd0);
		issue(ACT_TICK, 31'd0, 32'd0);
		issue(ACT_UNUSED, 31'h5555_5555, 32'hAAAA_AAAA);

		// Fill the store with equal deadlines, get one post refused,
		// then release the whole store on one tick.
		for (int i = 0; i < QUEUE_DEPTH; i++)
			issue(ACT_POST, 31'd1, 32'($urandom()));
		issue(ACT_POST, 31'd1, 32'd0);
		issue(ACT_TICK, 31'd0, 32'd0);
		issue(ACT_CANCEL, 31'd0, 32'd3);

		wait_drained();

		// Random bursts of requests with random gaps between them.
		random_sent = 0;
		mid_drained = 1'b0;
		while (random_sent < RANDOM_REQUESTS) begin
			burst_len = $urandom_range(1, 24);
			for (int i = 0; i < burst_len; i++) begin
				r = $urandom_range(0, 99);
				dly = pick_delay();
				cid = pick_cancel_id();
				if (r < 44)
					act = ACT_POST;
				else if (r < 64)
					act = ACT_CANCEL;
				else if (r < 96)
					act = ACT_TICK;
				else
					act = ACT_UNUSED;
				issue(act, dly, cid);
				if (act != ACT_UNUSED)
					random_sent++;
			end
			if (!mid_drained && random_sent >= RANDOM_REQUESTS / 2) begin
				wait_drained();
				mid_drained = 1'b1;
			end else if ($urandom_range(0, 3) != 0) begin
				idle($urandom_range(1, 12));
			end
		end

		// Let every result arrive, then give the block time to settle.
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d posts, %0d cancels, %0d ticks and %0d ignored codes in %0d cycles.",
			post_count, cancel_count, tick_count, ignored_count, cycle_count);
		$display("Checked %0d results: %0d releases, %0d refused posts, %0d cancel hits.",
			checked_count, release_count, refuse_count, hit_count);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/doeq_pkg.sv
hw/rtl/doeq_ram.sv
hw/rtl/doeq_ctrl.sv
hw/rtl/deadline_ordered_event_queue.sv
hw/rtl/doeq_checker.sv
sim/doeq_result_checker.sv
sim/tb_deadline_ordered_event_queue.sv
